// File: hdl/spoi_pkg.sv
`default_nettype none

package spoi_pkg;

  // Fixed field widths of the item and result words.
  localparam int PREFIX_W = 16;
  localparam int DELTA_W  = 32;
  localparam int RANGE_W  = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [0:0] {
    OP_ADJUST = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_ADD    = 6'b000100,
    S_REMOVE = 6'b001000,
    S_SHIFT  = 6'b010000,
    S_REPORT = 6'b100000
  } state_e;

  // Operand selection for the shared offset adder.
  typedef struct packed {
    logic search;
    logic shift;
    logic at_end;
  } alu_ctrl_t;

  typedef struct packed {
    logic lt;
    logic hit;
    logic span_zero;
  } alu_flags_t;

endpackage

`default_nettype wire

// File: hdl/spoi_ram.sv
`default_nettype none

module spoi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/spoi_alu.sv
`default_nettype none

module spoi_alu #(
  parameter int OFFSET_BITS = 32
) (
  input  spoi_pkg::alu_ctrl_t              ctrl_i,
  input  logic [spoi_pkg::PREFIX_W-1:0]    key_i,
  input  logic [spoi_pkg::PREFIX_W-1:0]    entry_prefix_i,
  input  logic [OFFSET_BITS-1:0]           entry_end_i,
  input  logic [OFFSET_BITS-1:0]           prev_i,
  input  logic [OFFSET_BITS-1:0]           buf_end_i,
  input  logic [OFFSET_BITS-1:0]           delta_i,
  output logic [OFFSET_BITS-1:0]           sum_o,
  output spoi_pkg::alu_flags_t             flags_o
);

  import spoi_pkg::*;

  logic                   hit;
  logic [OFFSET_BITS-1:0] operand;

  assign hit = !ctrl_i.at_end && (entry_prefix_i == key_i);

  // New entries start from the previous end; shifted entries come from the buffer.
  always_comb begin
    if (ctrl_i.shift) begin
      operand = buf_end_i;
    end else if (ctrl_i.search && !hit) begin
      operand = prev_i;
    end else begin
      operand = entry_end_i;
    end
  end

  assign sum_o             = operand + delta_i;
  assign flags_o.lt        = entry_prefix_i < key_i;
  assign flags_o.hit       = hit;
  assign flags_o.span_zero = sum_o == prev_i;

endmodule

`default_nettype wire

// File: hdl/sorted_prefix_offset_index_unit.sv
`default_nettype none

// Channel  | Direction | Handshake              | Word
// ---------+-----------+------------------------+-------------------------------------------
// in       | input     | in_valid_i/in_ready_o   | operation, key_prefix, size_change
// out      | output    | out_valid_o/out_ready_i | found, range_start, range_end, status
//
// An item's result is offered once its walk over the table is done, and in_ready_o
// rises together with that result. The walk visits one entry per cycle through the
// single read port of the table RAM and the shared offset adder.
// Reset (rst_ni low, asynchronous) empties the table; the RAM contents are not cleared.
// A waiting result does not block acceptance of the next item; it holds only the
// report step of that next item until the output register frees up.

module sorted_prefix_offset_index_unit #(
  parameter int MAX_ENTRIES = 64,
  parameter int OFFSET_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [spoi_pkg::PREFIX_W-1:0] key_prefix_i,
  input  logic signed [spoi_pkg::DELTA_W-1:0] size_change_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [spoi_pkg::RANGE_W-1:0]  range_start_o,
  output logic [spoi_pkg::RANGE_W-1:0]  range_end_o,
  output logic [spoi_pkg::STATUS_W-1:0] status_o
);

  import spoi_pkg::*;

  localparam int AddrW  = $clog2(MAX_ENTRIES);
  localparam int CntW   = $clog2(MAX_ENTRIES + 1);
  localparam int EntryW = PREFIX_W + OFFSET_BITS;

  // Control state.
  state_e          state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  // Item and walk payload.
  op_e                    op_q, op_d;
  logic [PREFIX_W-1:0]    key_q, key_d;
  logic [OFFSET_BITS-1:0] delta_q, delta_d;
  logic [OFFSET_BITS-1:0] prev_q, prev_d;
  logic [EntryW-1:0]      buf_q, buf_d;
  logic                   res_found_q, res_found_d;
  logic [OFFSET_BITS-1:0] res_rs_q, res_rs_d;
  logic [OFFSET_BITS-1:0] res_re_q, res_re_d;
  status_e                res_status_q, res_status_d;

  // Output register.
  logic                found_q, found_d;
  logic [RANGE_W-1:0]  rs_q, rs_d;
  logic [RANGE_W-1:0]  re_q, re_d;
  status_e             status_q, status_d;

  // Table RAM and shared adder.
  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr;
  logic [EntryW-1:0]      ram_wdata;
  logic [EntryW-1:0]      ram_rdata;
  logic [PREFIX_W-1:0]    ent_prefix;
  logic [OFFSET_BITS-1:0] ent_end;
  logic [OFFSET_BITS-1:0] sum;
  alu_ctrl_t              alu_ctrl;
  alu_flags_t             flags;
  logic                   at_end;
  logic                   table_full;
  logic                   slot_free;
  logic [CntW-1:0]        idx_m1;

  assign ent_prefix = ram_rdata[EntryW-1:OFFSET_BITS];
  assign ent_end    = ram_rdata[OFFSET_BITS-1:0];
  assign at_end     = idx_q == cnt_q;
  assign table_full = cnt_q == CntW'(MAX_ENTRIES);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign idx_m1     = idx_q - CntW'(1);

  assign alu_ctrl.search = state_q == S_SEARCH;
  assign alu_ctrl.shift  = state_q == S_SHIFT;
  assign alu_ctrl.at_end = at_end;

  spoi_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_d[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  spoi_alu #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_alu (
    .ctrl_i         (alu_ctrl),
    .key_i          (key_q),
    .entry_prefix_i (ent_prefix),
    .entry_end_i    (ent_end),
    .prev_i         (prev_q),
    .buf_end_i      (buf_q[OFFSET_BITS-1:0]),
    .delta_i        (delta_q),
    .sum_o          (sum),
    .flags_o        (flags)
  );

  // The read address runs one entry ahead of the write address, two in a removal,
  // so the walk sees each entry's old contents exactly once. An insert keeps the
  // displaced entry in a buffer and writes it one slot higher in the next cycle;
  // a removal writes each later entry one slot lower.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    op_d         = op_q;
    key_d        = key_q;
    delta_d      = delta_q;
    prev_d       = prev_q;
    buf_d        = buf_q;
    res_found_d  = res_found_q;
    res_rs_d     = res_rs_q;
    res_re_d     = res_re_q;
    res_status_d = res_status_q;
    found_d      = found_q;
    rs_d         = rs_q;
    re_d         = re_q;
    status_d     = status_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[AddrW-1:0];
    ram_wdata    = {ent_prefix, sum};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = op_e'(operation_i);
          key_d        = key_prefix_i;
          delta_d      = OFFSET_BITS'(size_change_i);
          idx_d        = '0;
          prev_d       = '0;
          res_found_d  = 1'b0;
          res_rs_d     = '0;
          res_re_d     = '0;
          res_status_d = ST_UPDATED;
          state_d      = S_SEARCH;
        end
      end

      S_SEARCH: begin
        if (at_end) begin
          // The key sorts after every entry.
          if (op_q == OP_LOOKUP) begin
            res_rs_d = prev_q;
            res_re_d = prev_q;
          end else if (table_full) begin
            res_status_d = ST_FULL;
          end else begin
            ram_we       = 1'b1;
            ram_wdata    = {key_q, sum};
            cnt_d        = cnt_q + CntW'(1);
            res_status_d = ST_INSERTED;
          end
          state_d = S_REPORT;
        end else if (flags.lt) begin
          prev_d = ent_end;
          idx_d  = idx_q + CntW'(1);
        end else if (op_q == OP_LOOKUP) begin
          res_found_d = flags.hit;
          res_rs_d    = prev_q;
          res_re_d    = flags.hit ? ent_end : prev_q;
          state_d     = S_REPORT;
        end else if (flags.hit) begin
          res_found_d = 1'b1;
          idx_d       = idx_q + CntW'(1);
          if (flags.span_zero) begin
            res_status_d = ST_REMOVED;
            state_d      = S_REMOVE;
          end else begin
            ram_we       = 1'b1;
            res_status_d = ST_UPDATED;
            state_d      = S_ADD;
          end
        end else if (table_full) begin
          res_status_d = ST_FULL;
          state_d      = S_REPORT;
        end else begin
          ram_we       = 1'b1;
          ram_wdata    = {key_q, sum};
          buf_d        = ram_rdata;
          res_status_d = ST_INSERTED;
          idx_d        = idx_q + CntW'(1);
          state_d      = S_SHIFT;
        end
      end

      S_ADD: begin
        if (at_end) begin
          state_d = S_REPORT;
        end else begin
          ram_we = 1'b1;
          idx_d  = idx_q + CntW'(1);
        end
      end

      S_REMOVE: begin
        if (at_end) begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = S_REPORT;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = idx_m1[AddrW-1:0];
          idx_d     = idx_q + CntW'(1);
        end
      end

      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_wdata = {buf_q[EntryW-1:OFFSET_BITS], sum};
        if (at_end) begin
          cnt_d   = cnt_q + CntW'(1);
          state_d = S_REPORT;
        end else begin
          buf_d = ram_rdata;
          idx_d = idx_q + CntW'(1);
        end
      end

      S_REPORT: begin
        if (slot_free) begin
          found_d     = res_found_q;
          rs_d        = RANGE_W'(res_rs_q);
          re_d        = RANGE_W'(res_re_q);
          status_d    = res_status_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    delta_q      <= delta_d;
    prev_q       <= prev_d;
    buf_q        <= buf_d;
    res_found_q  <= res_found_d;
    res_rs_q     <= res_rs_d;
    res_re_q     <= res_re_d;
    res_status_q <= res_status_d;
    found_q      <= found_d;
    rs_q         <= rs_d;
    re_q         <= re_d;
    status_q     <= status_d;
  end

  assign in_ready_o    = state_q == S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign range_start_o = rs_q;
  assign range_end_o   = re_q;
  assign status_o      = status_q;

endmodule

`default_nettype wire

// File: sim/sorted_prefix_offset_index_unit_tb.sv
`default_nettype none

module sorted_prefix_offset_index_unit_tb;
  import spoi_pkg::*;

  // The table depth and the offset width are left at the block's defaults.
  localparam int TABLE_DEPTH = 64;
  localparam int QUIET_LIMIT = 4000;

  // One input word and one result word as the channels carry them.
  typedef struct {
    op_e                op;
    logic [PREFIX_W-1:0] key;
    logic [DELTA_W-1:0]  delta;
  } index_word_t;

  typedef struct {
    logic               found;
    logic [RANGE_W-1:0] range_start;
    logic [RANGE_W-1:0] range_end;
    status_e            status;
  } index_result_t;

  // The random stimulus runs in rounds. The table is filled past capacity,
  // then churned, then drained, so every status shows up many times.
  typedef enum int {
    PH_GROW,
    PH_MIX,
    PH_SHRINK
  } phase_e;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       operation_i = OP_LOOKUP;
  logic [PREFIX_W-1:0]        key_prefix_i = '0;
  logic signed [DELTA_W-1:0]  size_change_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic                       found_o;
  logic [RANGE_W-1:0]         range_start_o;
  logic [RANGE_W-1:0]         range_end_o;
  logic [STATUS_W-1:0]        status_o;

  // The testbench only starts driving words once reset is released.
  logic run = 1'b0;

  // Shadow copy of the prefix table, kept in step with accepted words.
  logic [PREFIX_W-1:0] shadow_prefix [TABLE_DEPTH];
  logic [RANGE_W-1:0]  shadow_end    [TABLE_DEPTH];
  int                  shadow_count = 0;

  index_word_t   word_backlog[$];
  index_result_t predicted_results[$];

  int words_in       = 0;
  int words_out      = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  sorted_prefix_offset_index_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .key_prefix_i  (key_prefix_i),
    .size_change_i (size_change_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .range_start_o (range_start_o),
    .range_end_o   (range_end_o),
    .status_o      (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Applies one accepted word to the shadow table and returns the result the
  // block must produce for it. Offsets are 32 bits wide, so the vector
  // arithmetic wraps exactly as the block's offsets do.
  function automatic index_result_t index_apply(op_e op, logic [PREFIX_W-1:0] key,
                                                logic [DELTA_W-1:0] delta);
    index_result_t      res;
    int                 pos;
    bit                 hit;
    logic [RANGE_W-1:0] span_start;
    logic [RANGE_W-1:0] new_end;
    res.found       = 1'b0;
    res.range_start = '0;
    res.range_end   = '0;
    res.status      = ST_UPDATED;
    pos = 0;
    while (pos < shadow_count && shadow_prefix[pos] < key) pos++;
    hit = (pos < shadow_count) && (shadow_prefix[pos] == key);
    span_start = (pos == 0) ? '0 : shadow_end[pos-1];
    if (op == OP_LOOKUP) begin
      // An absent prefix gets an empty range at the place it would go.
      res.found       = hit;
      res.range_start = span_start;
      res.range_end   = hit ? shadow_end[pos] : span_start;
    end else if (hit) begin
      res.found = 1'b1;
      new_end = shadow_end[pos] + delta;
      if (new_end == span_start) begin
        // The span collapsed: close the gap, the later entries still move.
        for (int i = pos; i + 1 < shadow_count; i++) begin
          shadow_prefix[i] = shadow_prefix[i+1];
          shadow_end[i]    = shadow_end[i+1];
        end
        shadow_count--;
        res.status = ST_REMOVED;
      end
      for (int i = pos; i < shadow_count; i++) shadow_end[i] += delta;
    end else if (shadow_count >= TABLE_DEPTH) begin
      // A full table leaves everything untouched.
      res.status = ST_FULL;
    end else begin
      for (int i = shadow_count; i > pos; i--) begin
        shadow_prefix[i] = shadow_prefix[i-1];
        shadow_end[i]    = shadow_end[i-1];
      end
      shadow_prefix[pos] = key;
      shadow_end[pos]    = span_start + delta;
      shadow_count++;
      for (int i = pos + 1; i < shadow_count; i++) shadow_end[i] += delta;
      res.status = ST_INSERTED;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [RANGE_W-1:0] got,
                                 logic [RANGE_W-1:0] want);
    $display("tb: mismatch in result %0d, %s: got %0h, want %0h",
             words_out, what, got, want);
    mismatch_count++;
  endtask

  // Sender side. The prediction is taken at the edge where the word is
  // accepted, so the shadow table always matches what the block has taken in.
  // A new word is only raised when the current one is gone, and in_valid_i
  // gets at most one assignment per edge.
  always @(posedge clk_i) begin : drive_words
    index_word_t nxt;
    bit          calm;
    if (run) begin
      if (in_valid_i && in_ready_o) begin
        predicted_results.push_back(index_apply(op_e'(operation_i), key_prefix_i,
                                                size_change_i));
        words_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        // In a calm stretch the sender adds no random gaps between words.
        calm = (words_in >= 300 && words_in < 450);
        if (word_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 35)) begin
          nxt = word_backlog.pop_front();
          in_valid_i    <= 1'b1;
          operation_i   <= nxt.op;
          key_prefix_i  <= nxt.key;
          size_change_i <= nxt.delta;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver side: every accepted result is held against the oldest
  // prediction, and out_ready_i stalls at random outside a calm stretch.
  always @(posedge clk_i) begin : watch_results
    index_result_t want;
    bit            calm;
    if (run) begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result with nothing predicted", range_start_o, '0);
        end else begin
          want = predicted_results.pop_front();
          if (found_o !== want.found)
            report_mismatch("found", RANGE_W'(found_o), RANGE_W'(want.found));
          if (range_start_o !== want.range_start)
            report_mismatch("range_start", range_start_o, want.range_start);
          if (range_end_o !== want.range_end)
            report_mismatch("range_end", range_end_o, want.range_end);
          if (status_o !== want.status)
            report_mismatch("status", RANGE_W'(status_o), RANGE_W'(want.status));
        end
        words_out++;
      end
      calm = (words_out >= 600 && words_out < 750);
      out_ready_i <= calm || ($urandom_range(0, 99) >= 35);
    end
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (run) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Words are built one at a time, once the previous word has been accepted
  // and predicted, so that state-dependent words (exact removals, hits on
  // present prefixes) are built from the table as the block holds it.
  task automatic wait_turn();
    @(negedge clk_i);
    while (word_backlog.size() != 0 || in_valid_i) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (word_backlog.size() != 0 || in_valid_i || predicted_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic send_word(op_e op, logic [PREFIX_W-1:0] key, logic [DELTA_W-1:0] delta);
    index_word_t w;
    wait_turn();
    w.op    = op;
    w.key   = key;
    w.delta = delta;
    word_backlog.push_back(w);
  endtask

  // The size change that brings the prefix's span back to zero bytes.
  function automatic logic [DELTA_W-1:0] collapse_delta(logic [PREFIX_W-1:0] key);
    int pos;
    pos = 0;
    while (pos < shadow_count && shadow_prefix[pos] < key) pos++;
    if (pos >= shadow_count || shadow_prefix[pos] != key) return '0;
    return ((pos == 0) ? '0 : shadow_end[pos-1]) - shadow_end[pos];
  endfunction

  task automatic send_removal(logic [PREFIX_W-1:0] key);
    index_word_t w;
    wait_turn();
    w.op    = OP_ADJUST;
    w.key   = key;
    w.delta = collapse_delta(key);
    word_backlog.push_back(w);
  endtask

  function automatic logic [DELTA_W-1:0] pick_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(1, 200);
    if (r < 55) return -$urandom_range(1, 200);
    if (r < 80) return $urandom();
    if (r < 90) return '0;
    return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [PREFIX_W-1:0] pick_fresh_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return '1;
    return PREFIX_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [PREFIX_W-1:0] pick_present_key();
    if (shadow_count == 0) return pick_fresh_key();
    return shadow_prefix[$urandom_range(0, shadow_count - 1)];
  endfunction

  task automatic send_random(phase_e phase);
    index_word_t w;
    int          r;
    int          ins_top;
    int          adj_top;
    int          look_top;
    wait_turn();
    case (phase)
      PH_GROW: begin
        ins_top = 70; adj_top = 82; look_top = 94;
      end
      PH_MIX: begin
        ins_top = 25; adj_top = 55; look_top = 80;
      end
      default: begin
        ins_top = 10; adj_top = 30; look_top = 50;
      end
    endcase
    r = $urandom_range(0, 99);
    w.op = OP_ADJUST;
    if (r < ins_top) begin
      w.key   = pick_fresh_key();
      w.delta = pick_delta();
    end else if (r < adj_top) begin
      w.key   = pick_present_key();
      w.delta = pick_delta();
    end else if (r < look_top) begin
      // The size change is ignored on a lookup, so it carries random bits.
      w.op    = OP_LOOKUP;
      w.key   = ($urandom_range(0, 1) != 0) ? pick_present_key() : pick_fresh_key();
      w.delta = $urandom();
    end else begin
      w.key   = pick_present_key();
      w.delta = collapse_delta(w.key);
    end
    word_backlog.push_back(w);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run <= 1'b1;

    // Lookup in the empty table.
    send_word(OP_LOOKUP, 16'h1234, 32'h0);
    // First entry, an empty span at the front, an append at the top key,
    // and a middle insert whose change makes the later offsets wrap.
    send_word(OP_ADJUST, 16'h8000, 32'd100);
    send_word(OP_ADJUST, 16'h0000, 32'h0);
    send_word(OP_ADJUST, 16'hFFFF, 32'h7FFF_FFFF);
    send_word(OP_ADJUST, 16'h4000, 32'h8000_0000);
    // Hits, an absent prefix between entries, and the empty span.
    send_word(OP_LOOKUP, 16'h8000, 32'hFFFF_FFFF);
    send_word(OP_LOOKUP, 16'h5000, 32'h0);
    send_word(OP_LOOKUP, 16'h0000, 32'h0);
    send_word(OP_LOOKUP, 16'hFFFF, 32'h0);
    // Plain updates in both directions.
    send_word(OP_ADJUST, 16'h8000, 32'd5);
    send_word(OP_ADJUST, 16'h8000, -32'sd3);
    // Removals: the empty span with no change, then the first entry with the
    // later entries still taking the change, then the last entry.
    send_removal(16'h0000);
    send_removal(16'h4000);
    send_word(OP_LOOKUP, 16'h4000, 32'h0);
    send_word(OP_ADJUST, 16'h0001, 32'hFFFF_FFFF);
    send_word(OP_LOOKUP, 16'h0000, 32'h0);
    send_word(OP_LOOKUP, 16'hFFFF, 32'h0);
    send_removal(16'hFFFF);
    send_word(OP_LOOKUP, 16'hFFFF, 32'h0);
    send_word(OP_ADJUST, 16'h7FFF, 32'h1234_5678);
    send_word(OP_LOOKUP, 16'h8000, 32'h0);

    // The sender holds off here until every result is back.
    wait_drained();

    for (int round = 0; round < 4; round++) begin
      repeat (120) send_random(PH_GROW);
      wait_drained();
      repeat (60) send_random(PH_MIX);
      repeat (70) send_random(PH_SHRINK);
      wait_drained();
    end

    // Let the block settle and catch any stray result.
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
